[hw/rtl/ils_pkg.sv]
// Shared types, constants and saturating helpers for the iterative linear solver.
// Used by ils_arith, ils_core and iterative_linear_solver_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

   localparam int N         = 128;
   localparam int FRAC_BITS = 48;
   localparam int IDX_W     = $clog2(N);
   localparam int CNT_W     = $clog2(N) + 1;
   localparam int MAT_AW    = 2 * IDX_W;
   localparam int DATA_W    = 64;
   localparam int ROW_W     = 7;
   localparam int METHOD_W  = 2;
   localparam int SWEEP_W   = 16;
   localparam int RELAX_W   = 50;
   localparam int SIZE_W    = 8;
   localparam int STEP_W    = 6;
   localparam int HALF_W    = DATA_W / 2;
   localparam int ADDR_W    = 5;

   localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] POS_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] ONE_FX   = DATA_W'(1) << FRAC_BITS;

   localparam logic [METHOD_W-1:0] METHOD_JACOBI = 2'd0;
   localparam logic [METHOD_W-1:0] METHOD_GS     = 2'd1;
   localparam logic [METHOD_W-1:0] METHOD_SOR    = 2'd2;

   localparam logic [1:0] REQ_WR_MATRIX = 2'd0;
   localparam logic [1:0] REQ_WR_RHS    = 2'd1;
   localparam logic [1:0] REQ_START     = 2'd2;
   localparam logic [1:0] REQ_READ      = 2'd3;

   localparam logic [1:0] REG_METHOD = 2'd0;
   localparam logic [1:0] REG_SWEEPS = 2'd1;
   localparam logic [1:0] REG_RELAX  = 2'd2;
   localparam logic [1:0] REG_SIZE   = 2'd3;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [METHOD_W-1:0] RST_METHOD = METHOD_JACOBI;
   localparam logic [SWEEP_W-1:0]  RST_SWEEPS = 16'd10000;
   localparam logic [RELAX_W-1:0]  RST_RELAX  = RELAX_W'(1) << (FRAC_BITS - 1);
   localparam logic [SIZE_W-1:0]   RST_SIZE   = 8'd99;

   typedef enum logic [4:0] {
      S_IDLE, S_RD_DATA, S_RESULT, S_ROW, S_ROW_D, S_TERM, S_TERM_D, S_TERM_MUL,
      S_FINISH, S_SOR1, S_SOR2, S_SOR3, S_DIVJ, S_WRITE, S_COPY, S_COPY_D, S_SWEEP_END
   } seq_state_type;

   typedef enum logic [2:0] {A_IDLE, A_MUL, A_DCHK, A_DIV, A_PACK} arith_state_type;

   typedef enum logic {OP_MUL, OP_DIV} arith_op_type;

   typedef struct packed {
      logic              start;
      arith_op_type      op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } arith_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] value;
      logic              ovf;
   } arith_rsp_type;

   typedef struct packed {
      logic [METHOD_W-1:0] method;
      logic [SWEEP_W-1:0]  sweeps;
      logic [RELAX_W-1:0]  relax;
      logic [CNT_W-1:0]    n_eff;
   } cfg_type;

   typedef struct packed {
      logic              kind;
      logic [ROW_W-1:0]  index;
      logic [DATA_W-1:0] value;
      logic              error;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              ovf;
   } sat_type;

   function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
   endfunction

   function automatic sat_type sat_add(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b);
      sat_type           r;
      logic [DATA_W-1:0] sum;
      sum     = a + b;
      r.value = sum;
      r.ovf   = 1'b0;
      if ((a[DATA_W-1] == b[DATA_W-1]) && (sum[DATA_W-1] != a[DATA_W-1])) begin
         r.ovf   = 1'b1;
         r.value = a[DATA_W-1] ? SIGN_BIT : POS_MAX;
      end
      return r;
   endfunction

   function automatic sat_type sat_sub(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b);
      sat_type           r;
      logic [DATA_W-1:0] diff;
      diff    = a - b;
      r.value = diff;
      r.ovf   = 1'b0;
      if ((a[DATA_W-1] != b[DATA_W-1]) && (diff[DATA_W-1] != a[DATA_W-1])) begin
         r.ovf   = 1'b1;
         r.value = a[DATA_W-1] ? SIGN_BIT : POS_MAX;
      end
      return r;
   endfunction

   function automatic sat_type sat_neg(input logic [DATA_W-1:0] v);
      sat_type r;
      r.ovf   = (v == SIGN_BIT);
      r.value = r.ovf ? POS_MAX : (~v + DATA_W'(1));
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/ils_arith.sv]
// Shared fixed-point multiply/divide unit: 32x32 partial products and a
// restoring divider one quotient bit per cycle, saturating result. Uses ils_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ils_arith
   import ils_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  arith_req_type req,
   output arith_rsp_type rsp
);

   arith_state_type      state_ff, state_in;
   logic                 neg_ff, neg_in;
   logic [DATA_W-1:0]    ma_ff, ma_in, mb_ff, mb_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DATA_W-1:0]    prod_ff, prod_in;
   logic [1:0]           prod_sh_ff, prod_sh_in;
   logic [2*DATA_W-1:0]  acc_ff, acc_in;
   logic [DATA_W:0]      rem_ff, rem_in;
   logic [DATA_W-1:0]    lo_ff, lo_in, q_ff, q_in;
   logic                 is_div_ff, is_div_in;
   logic                 dovf_ff, dovf_in;
   logic [DATA_W-1:0]    res_ff, res_in;
   logic                 sat_ff, sat_in;
   logic                 done_ff, done_in;

   logic [DATA_W-1:0]    ua, ub;
   logic [HALF_W-1:0]    pa, pb;
   logic [DATA_W:0]      rem_sh;
   logic                 ge;
   logic [DATA_W-1:0]    mag;
   logic                 hi_ovf, neg_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      neg_ff     <= neg_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      step_ff    <= step_in;
      prod_ff    <= prod_in;
      prod_sh_ff <= prod_sh_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      lo_ff      <= lo_in;
      q_ff       <= q_in;
      is_div_ff  <= is_div_in;
      dovf_ff    <= dovf_in;
      res_ff     <= res_in;
      sat_ff     <= sat_in;
   end

   always_comb begin
      state_in   = state_ff;
      neg_in     = neg_ff;
      ma_in      = ma_ff;
      mb_in      = mb_ff;
      step_in    = step_ff;
      prod_in    = prod_ff;
      prod_sh_in = prod_sh_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      lo_in      = lo_ff;
      q_in       = q_ff;
      is_div_in  = is_div_ff;
      dovf_in    = dovf_ff;
      res_in     = res_ff;
      sat_in     = sat_ff;
      done_in    = 1'b0;
      ua         = magnitude(req.a);
      ub         = magnitude(req.b);
      pa         = step_ff[1] ? ma_ff[DATA_W-1:HALF_W] : ma_ff[HALF_W-1:0];
      pb         = step_ff[0] ? mb_ff[DATA_W-1:HALF_W] : mb_ff[HALF_W-1:0];
      rem_sh     = {rem_ff[DATA_W-1:0], lo_ff[DATA_W-1]};
      ge         = (rem_sh >= {1'b0, mb_ff});
      mag        = is_div_ff ? q_ff : acc_ff[FRAC_BITS +: DATA_W];
      hi_ovf     = is_div_ff ? dovf_ff : (|acc_ff[2*DATA_W-1:FRAC_BITS+DATA_W]);
      neg_out    = neg_ff && ((mag != '0) || (is_div_ff && dovf_ff));

      unique case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               neg_in    = req.a[DATA_W-1] ^ req.b[DATA_W-1];
               ma_in     = ua;
               mb_in     = ub;
               step_in   = '0;
               acc_in    = '0;
               q_in      = '0;
               dovf_in   = 1'b0;
               rem_in    = (DATA_W+1)'(ua >> (DATA_W - FRAC_BITS));
               lo_in     = ua << FRAC_BITS;
               is_div_in = (req.op == OP_DIV);
               state_in  = (req.op == OP_DIV) ? A_DCHK : A_MUL;
            end
         end
         A_MUL: begin
            if (step_ff != '0) begin
               acc_in = acc_ff + ((2*DATA_W)'(prod_ff) << {prod_sh_ff, 5'd0});
            end
            prod_in    = pa * pb;
            prod_sh_in = 2'(step_ff[1]) + 2'(step_ff[0]);
            step_in    = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(4)) begin
               state_in = A_PACK;
            end
         end
         A_DCHK: begin
            step_in = '0;
            if (rem_ff >= {1'b0, mb_ff}) begin
               dovf_in  = 1'b1;
               state_in = A_PACK;
            end else begin
               state_in = A_DIV;
            end
         end
         A_DIV: begin
            lo_in   = lo_ff << 1;
            q_in    = {q_ff[DATA_W-2:0], ge};
            rem_in  = ge ? (rem_sh - {1'b0, mb_ff}) : rem_sh;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == {STEP_W{1'b1}}) begin
               state_in = A_PACK;
            end
         end
         A_PACK: begin
            if (neg_out) begin
               sat_in = hi_ovf || (mag > SIGN_BIT);
               res_in = sat_in ? SIGN_BIT : (~mag + DATA_W'(1));
            end else begin
               sat_in = hi_ovf || mag[DATA_W-1];
               res_in = sat_in ? POS_MAX : mag;
            end
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;
   assign rsp.ovf   = sat_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> (state_ff == A_IDLE))
      else $error("arith start while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("arith done held");
   a_sign_ok: assert property (@(posedge clock) disable iff (reset)
      (done_ff && res_ff[DATA_W-1]) |-> neg_ff)
      else $error("negative result from positive operands");
`endif

endmodule

`default_nettype wire

[hw/rtl/ils_core.sv]
// Solver sequencer: matrix, rhs and solution memories and the sweep/row/term
// control around the shared ils_arith unit. Uses ils_pkg and ils_arith.
`timescale 1ns / 1ps
`default_nettype none

module ils_core
   import ils_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [ROW_W-1:0]  req_row,
   input  logic [ROW_W-1:0]  req_col,
   input  logic [DATA_W-1:0] req_value,
   input  cfg_type           cfg,
   output logic              res_valid,
   input  logic              res_ready,
   output rsp_type           res
);

   seq_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic [SWEEP_W-1:0] sweep_ff, sweep_in;
   logic [DATA_W-1:0]  s_ff, s_in, diag_ff, diag_in, xi_ff, xi_in;
   logic [DATA_W-1:0]  t1_ff, t1_in, nv_ff, nv_in;
   logic               err_ff, err_in;
   logic [N-1:0]       x_valid_ff;
   logic               res_kind_ff, res_kind_in;
   logic [ROW_W-1:0]   res_index_ff, res_index_in;
   logic [DATA_W-1:0]  res_value_ff, res_value_in;

   logic [DATA_W-1:0]  mat_mem [N*N];
   logic [DATA_W-1:0]  rhs_mem [N];
   logic [DATA_W-1:0]  x_mem [N];
   logic [DATA_W-1:0]  nx_mem [N];
   logic [DATA_W-1:0]  mat_rd_ff, rhs_rd_ff, x_rd_ff, nx_rd_ff;
   logic               x_rv_ff;

   logic               mat_we, mat_re, rhs_we, rhs_re, x_we, x_re, nx_we, nx_re, x_clear;
   logic [MAT_AW-1:0]  mat_waddr, mat_raddr;
   logic [IDX_W-1:0]   rhs_waddr, x_waddr, x_raddr, nx_addr;
   logic [DATA_W-1:0]  x_wdata;
   logic               inplace, is_sor;
   logic [DATA_W-1:0]  w64, x_op;
   sat_type            sa;
   arith_req_type      arq;
   arith_rsp_type      ars;

   ils_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (arq),
      .rsp   (ars)
   );

   assign inplace   = (cfg.method == METHOD_GS) || (cfg.method == METHOD_SOR);
   assign is_sor    = (cfg.method == METHOD_SOR);
   assign w64       = DATA_W'(cfg.relax);
   assign x_op      = x_rv_ff ? x_rd_ff : '0;
   assign mat_waddr = {IDX_W'(req_row), IDX_W'(req_col)};
   assign rhs_waddr = IDX_W'(req_row);

   always_ff @(posedge clock) begin
      if (mat_we) mat_mem[mat_waddr] <= req_value;
      if (mat_re) mat_rd_ff <= mat_mem[mat_raddr];
      if (rhs_we) rhs_mem[rhs_waddr] <= req_value;
      if (rhs_re) rhs_rd_ff <= rhs_mem[i_ff[IDX_W-1:0]];
      if (x_we) x_mem[x_waddr] <= x_wdata;
      if (x_re) begin
         x_rd_ff <= x_mem[x_raddr];
         x_rv_ff <= x_valid_ff[x_raddr];
      end
      if (nx_we) nx_mem[nx_addr] <= nv_ff;
      if (nx_re) nx_rd_ff <= nx_mem[nx_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         err_ff     <= 1'b0;
         x_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
         if (x_clear) begin
            x_valid_ff <= '0;
         end else if (x_we) begin
            x_valid_ff[x_waddr] <= 1'b1;
         end
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      sweep_ff     <= sweep_in;
      s_ff         <= s_in;
      diag_ff      <= diag_in;
      xi_ff        <= xi_in;
      t1_ff        <= t1_in;
      nv_ff        <= nv_in;
      res_kind_ff  <= res_kind_in;
      res_index_ff <= res_index_in;
      res_value_ff <= res_value_in;
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      sweep_in     = sweep_ff;
      s_in         = s_ff;
      diag_in      = diag_ff;
      xi_in        = xi_ff;
      t1_in        = t1_ff;
      nv_in        = nv_ff;
      err_in       = err_ff;
      res_kind_in  = res_kind_ff;
      res_index_in = res_index_ff;
      res_value_in = res_value_ff;
      mat_we       = 1'b0;
      mat_re       = 1'b0;
      mat_raddr    = {i_ff[IDX_W-1:0], j_ff[IDX_W-1:0]};
      rhs_we       = 1'b0;
      rhs_re       = 1'b0;
      x_we         = 1'b0;
      x_re         = 1'b0;
      x_raddr      = j_ff[IDX_W-1:0];
      x_waddr      = i_ff[IDX_W-1:0];
      x_wdata      = nv_ff;
      nx_we        = 1'b0;
      nx_re        = 1'b0;
      nx_addr      = i_ff[IDX_W-1:0];
      x_clear      = 1'b0;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      sa           = sat_add(s_ff, ars.value);
      arq.start    = 1'b0;
      arq.op       = OP_MUL;
      arq.a        = mat_rd_ff;
      arq.b        = x_op;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_type)
                  REQ_WR_MATRIX: mat_we = 1'b1;
                  REQ_WR_RHS:    rhs_we = 1'b1;
                  REQ_START: begin
                     err_in       = 1'b0;
                     x_clear      = 1'b1;
                     sweep_in     = '0;
                     i_in         = '0;
                     res_kind_in  = KIND_DONE;
                     res_index_in = '0;
                     res_value_in = '0;
                     state_in     = (cfg.sweeps == '0) ? S_RESULT : S_ROW;
                  end
                  REQ_READ: begin
                     x_re         = 1'b1;
                     x_raddr      = IDX_W'(req_row);
                     res_kind_in  = KIND_READ;
                     res_index_in = req_row;
                     state_in     = S_RD_DATA;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RD_DATA: begin
            res_value_in = x_op;
            state_in     = S_RESULT;
         end
         S_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) state_in = S_IDLE;
         end
         S_ROW: begin
            mat_re    = 1'b1;
            mat_raddr = {i_ff[IDX_W-1:0], i_ff[IDX_W-1:0]};
            rhs_re    = 1'b1;
            x_re      = 1'b1;
            x_raddr   = i_ff[IDX_W-1:0];
            state_in  = S_ROW_D;
         end
         S_ROW_D: begin
            s_in     = sat_neg(rhs_rd_ff).value;
            err_in   = err_ff | sat_neg(rhs_rd_ff).ovf;
            diag_in  = mat_rd_ff;
            xi_in    = x_op;
            j_in     = '0;
            state_in = S_TERM;
         end
         S_TERM: begin
            if (j_ff == cfg.n_eff) begin
               state_in = S_FINISH;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + CNT_W'(1);
            end else begin
               mat_re   = 1'b1;
               x_re     = 1'b1;
               state_in = S_TERM_D;
            end
         end
         S_TERM_D: begin
            arq.start = 1'b1;
            state_in  = S_TERM_MUL;
         end
         S_TERM_MUL: begin
            if (ars.done) begin
               s_in     = sa.value;
               err_in   = err_ff | ars.ovf | sa.ovf;
               j_in     = j_ff + CNT_W'(1);
               state_in = S_TERM;
            end
         end
         S_FINISH: begin
            if (diag_ff == '0) begin
               err_in   = 1'b1;
               nv_in    = xi_ff;
               state_in = S_WRITE;
            end else if (is_sor) begin
               arq.start = 1'b1;
               arq.a     = ONE_FX - w64;
               arq.b     = xi_ff;
               state_in  = S_SOR1;
            end else begin
               arq.start = 1'b1;
               arq.op    = OP_DIV;
               arq.a     = s_ff;
               arq.b     = diag_ff;
               state_in  = S_DIVJ;
            end
         end
         S_SOR1: begin
            if (ars.done) begin
               t1_in     = ars.value;
               err_in    = err_ff | ars.ovf;
               arq.start = 1'b1;
               arq.a     = w64;
               arq.b     = s_ff;
               state_in  = S_SOR2;
            end
         end
         S_SOR2: begin
            if (ars.done) begin
               err_in    = err_ff | ars.ovf;
               arq.start = 1'b1;
               arq.op    = OP_DIV;
               arq.a     = ars.value;
               arq.b     = diag_ff;
               state_in  = S_SOR3;
            end
         end
         S_SOR3: begin
            if (ars.done) begin
               nv_in    = sat_sub(t1_ff, ars.value).value;
               err_in   = err_ff | ars.ovf | sat_sub(t1_ff, ars.value).ovf;
               state_in = S_WRITE;
            end
         end
         S_DIVJ: begin
            if (ars.done) begin
               nv_in    = sat_neg(ars.value).value;
               err_in   = err_ff | ars.ovf | sat_neg(ars.value).ovf;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (inplace) begin
               x_we = 1'b1;
            end else begin
               nx_we = 1'b1;
            end
            i_in = i_ff + CNT_W'(1);
            j_in = '0;
            if (i_ff + CNT_W'(1) == cfg.n_eff) begin
               state_in = inplace ? S_SWEEP_END : S_COPY;
            end else begin
               state_in = S_ROW;
            end
         end
         S_COPY: begin
            nx_re    = 1'b1;
            nx_addr  = j_ff[IDX_W-1:0];
            state_in = S_COPY_D;
         end
         S_COPY_D: begin
            x_we     = 1'b1;
            x_waddr  = j_ff[IDX_W-1:0];
            x_wdata  = nx_rd_ff;
            j_in     = j_ff + CNT_W'(1);
            state_in = (j_ff + CNT_W'(1) == cfg.n_eff) ? S_SWEEP_END : S_COPY;
         end
         S_SWEEP_END: begin
            sweep_in = sweep_ff + SWEEP_W'(1);
            i_in     = '0;
            state_in = (sweep_ff + SWEEP_W'(1) == cfg.sweeps) ? S_RESULT : S_ROW;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res.kind  = res_kind_ff;
   assign res.index = res_index_ff;
   assign res.value = res_value_ff;
   assign res.error = err_ff;

`ifndef SYNTHESIS
   a_no_diag_term: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TERM_D) |-> (j_ff != i_ff))
      else $error("diagonal used as off-diagonal term");
   a_sweep_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP_END) |-> (i_ff == cfg.n_eff))
      else $error("sweep ended before last row");
   a_jacobi_buffered: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WRITE) && x_we) |-> inplace)
      else $error("solution overwritten during Jacobi sweep");
`endif

endmodule

`default_nettype wire

[hw/rtl/iterative_linear_solver_unit.sv]
// Iterative linear solver (Jacobi, Gauss-Seidel, SOR) in signed Q16.48.
// Top level: APB-style register port, result register, ils_core. Uses ils_pkg.
//
// req channel: req_type 0 loads A[row][col], 1 loads b[row], 2 starts a solve,
// 3 reads x[row]. Loads produce no item. A read gives one rsp item (kind 1)
// by way of S_RD_DATA and S_RESULT. A start clears x and the error flag, runs
// sweep_count sweeps over n = active_size unknowns (0 taken as 1, at most 128)
// and gives one rsp item (kind 0, error flag attached).
// Solve time is set by the shared multiply/divide unit, which serves each
// off-diagonal term and the divide of each row (SOR adds two multiplies);
// each Jacobi sweep adds a copy of the buffered solution into x.
// req_ready is low while an item is in work; a finished item sits in the rsp
// register, so loads are still taken while the receiver stalls, and the next
// read or start completes once that register is taken.
// Reset (synchronous, active high) sets the registers to their defaults and
// marks x as all zero; A and b hold nothing defined until loaded.
// Registers at 8-byte spacing: method, sweep_count, relax_factor, active_size.
`timescale 1ns / 1ps
`default_nettype none

module iterative_linear_solver_unit
   import ils_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [ROW_W-1:0]    req_row,
   input  logic [ROW_W-1:0]    req_col,
   input  logic [DATA_W-1:0]   req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_kind,
   output logic [ROW_W-1:0]    rsp_index,
   output logic [DATA_W-1:0]   rsp_value_res,
   output logic                rsp_error,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   logic [METHOD_W-1:0] method_ff;
   logic [SWEEP_W-1:0]  sweeps_ff;
   logic [RELAX_W-1:0]  relax_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic                out_valid_ff;
   rsp_type             out_ff;
   logic                wr_en;
   logic [1:0]          reg_idx;
   cfg_type             cfg;
   logic                res_valid, res_ready;
   rsp_type             res;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1:3];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= RST_METHOD;
         sweeps_ff <= RST_SWEEPS;
         relax_ff  <= RST_RELAX;
         size_ff   <= RST_SIZE;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_METHOD: method_ff <= pwdata[METHOD_W-1:0];
            REG_SWEEPS: sweeps_ff <= pwdata[SWEEP_W-1:0];
            REG_RELAX:  relax_ff  <= pwdata[RELAX_W-1:0];
            REG_SIZE:   size_ff   <= pwdata[SIZE_W-1:0];
            default:    size_ff   <= size_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_METHOD: prdata = DATA_W'(method_ff);
         REG_SWEEPS: prdata = DATA_W'(sweeps_ff);
         REG_RELAX:  prdata = DATA_W'(relax_ff);
         REG_SIZE:   prdata = DATA_W'(size_ff);
         default:    prdata = '0;
      endcase
   end

   always_comb begin
      cfg.method = method_ff;
      cfg.sweeps = sweeps_ff;
      cfg.relax  = relax_ff;
      priority if (size_ff == '0) begin
         cfg.n_eff = CNT_W'(1);
      end else if (int'(size_ff) > N) begin
         cfg.n_eff = CNT_W'(N);
      end else begin
         cfg.n_eff = CNT_W'(size_ff);
      end
   end

   ils_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_row   (req_row),
      .req_col   (req_col),
      .req_value (req_value),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_ready) begin
         out_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_ff.kind;
   assign rsp_index     = out_ff.index;
   assign rsp_value_res = out_ff.value;
   assign rsp_error     = out_ff.error;

endmodule

`default_nettype wire

[tb/ils_result_checker.sv]
// Result checker for iterative_linear_solver_unit: follows register writes and
// request items, predicts every response item and compares it field by field.
// Depends on ils_pkg for widths, codes and the response struct.
`timescale 1ns / 1ps

module ils_result_checker
   import ils_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [ROW_W-1:0]  req_row,
   input  logic [ROW_W-1:0]  req_col,
   input  logic [DATA_W-1:0] req_value,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_kind,
   input  logic [ROW_W-1:0]  rsp_index,
   input  logic [DATA_W-1:0] rsp_value_res,
   input  logic              rsp_error,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output int                fail_count,
   output int                pending
);

   logic [DATA_W-1:0]   a_mem [0:N*N-1];
   logic [DATA_W-1:0]   b_mem [0:N-1];
   logic [DATA_W-1:0]   x_cur [0:N-1];
   logic [DATA_W-1:0]   x_nxt [0:N-1];
   bit                  sat_flag;
   logic [METHOD_W-1:0] cfg_method;
   logic [SWEEP_W-1:0]  cfg_sweeps;
   logic [RELAX_W-1:0]  cfg_relax;
   logic [SIZE_W-1:0]   cfg_size;
   rsp_type             solver_rsp_q [$];

   function automatic logic [DATA_W-1:0] abs_of(logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? -v : v;
   endfunction

   function automatic logic [DATA_W-1:0] clamp(bit neg, logic [DATA_W-1:0] m, bit ovf);
      if (neg) begin
         if (ovf || m > SIGN_BIT) begin
            sat_flag = 1;
            return SIGN_BIT;
         end
         return -m;
      end
      if (ovf || m > POS_MAX) begin
         sat_flag = 1;
         return POS_MAX;
      end
      return m;
   endfunction

   function automatic logic [DATA_W-1:0] q_add(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] r;
      r = a + b;
      if (a[DATA_W-1] == b[DATA_W-1] && r[DATA_W-1] != a[DATA_W-1]) begin
         sat_flag = 1;
         return a[DATA_W-1] ? SIGN_BIT : POS_MAX;
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] q_sub(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] r;
      r = a - b;
      if (a[DATA_W-1] != b[DATA_W-1] && r[DATA_W-1] != a[DATA_W-1]) begin
         sat_flag = 1;
         return a[DATA_W-1] ? SIGN_BIT : POS_MAX;
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] q_neg(logic [DATA_W-1:0] v);
      if (v == SIGN_BIT) begin
         sat_flag = 1;
         return POS_MAX;
      end
      return -v;
   endfunction

   function automatic logic [DATA_W-1:0] q_mul(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic [127:0]      p;
      logic [DATA_W-1:0] m;
      bit                neg;
      neg = a[DATA_W-1] ^ b[DATA_W-1];
      p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
      m = p[FRAC_BITS+63:FRAC_BITS];
      if (m == 0) neg = 0;
      return clamp(neg, m, |p[127:FRAC_BITS+64]);
   endfunction

   function automatic logic [DATA_W-1:0] q_div(logic [DATA_W-1:0] num, logic [DATA_W-1:0] den);
      logic [127:0]      q;
      logic [DATA_W-1:0] un, ud;
      bit                neg;
      neg = num[DATA_W-1] ^ den[DATA_W-1];
      un = abs_of(num);
      ud = abs_of(den);
      if ((un >> (DATA_W - FRAC_BITS)) >= ud) return clamp(neg, 0, 1);
      q = ({64'd0, un} << FRAC_BITS) / {64'd0, ud};
      if (q[63:0] == 0) neg = 0;
      return clamp(neg, q[63:0], 0);
   endfunction

   function automatic void predict_solve();
      int                n;
      logic [DATA_W-1:0] w, omw, s, diag, nv;
      n = (cfg_size == 0) ? 1 : (cfg_size > N) ? N : int'(cfg_size);
      w = {14'd0, cfg_relax};
      omw = ONE_FX - w;
      sat_flag = 0;
      for (int k = 0; k < N; k++) x_cur[k] = '0;
      for (int sw = 0; sw < cfg_sweeps; sw++) begin
         for (int i = 0; i < n; i++) begin
            s = q_neg(b_mem[i]);
            diag = a_mem[i*N+i];
            for (int j = 0; j < n; j++)
               if (j != i) s = q_add(s, q_mul(a_mem[i*N+j], x_cur[j]));
            if (diag == 0) begin
               sat_flag = 1;
               nv = x_cur[i];
            end else if (cfg_method == METHOD_SOR) begin
               nv = q_sub(q_mul(omw, x_cur[i]), q_div(q_mul(w, s), diag));
            end else begin
               nv = q_neg(q_div(s, diag));
            end
            if (cfg_method == METHOD_GS || cfg_method == METHOD_SOR) x_cur[i] = nv;
            else x_nxt[i] = nv;
         end
         if (cfg_method != METHOD_GS && cfg_method != METHOD_SOR)
            for (int k = 0; k < n; k++) x_cur[k] = x_nxt[k];
      end
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            x_cur[k] = '0;
            x_nxt[k] = '0;
         end
         sat_flag = 0;
         cfg_method = RST_METHOD;
         cfg_sweeps = RST_SWEEPS;
         cfg_relax = RST_RELAX;
         cfg_size = RST_SIZE;
         solver_rsp_q.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               REG_METHOD: cfg_method = pwdata[METHOD_W-1:0];
               REG_SWEEPS: cfg_sweeps = pwdata[SWEEP_W-1:0];
               REG_RELAX:  cfg_relax = pwdata[RELAX_W-1:0];
               REG_SIZE:   cfg_size = pwdata[SIZE_W-1:0];
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_type)
               REQ_WR_MATRIX: a_mem[req_row*N+req_col] = req_value;
               REQ_WR_RHS:    b_mem[req_row] = req_value;
               REQ_START: begin
                  predict_solve();
                  e.kind = KIND_DONE;
                  e.index = '0;
                  e.value = '0;
                  e.error = sat_flag;
                  solver_rsp_q.push_back(e);
               end
               REQ_READ: begin
                  e.kind = KIND_READ;
                  e.index = req_row;
                  e.value = x_cur[req_row];
                  e.error = sat_flag;
                  solver_rsp_q.push_back(e);
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (solver_rsp_q.size() == 0) begin
               $error("unexpected response item kind=%0d index=%0d", rsp_kind, rsp_index);
               fail_count++;
            end else begin
               e = solver_rsp_q.pop_front();
               if (rsp_kind !== e.kind) begin
                  $error("kind: expected %0d, got %0d", e.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_index !== e.index) begin
                  $error("index: expected %0d, got %0d", e.index, rsp_index);
                  fail_count++;
               end
               if (rsp_value_res !== e.value) begin
                  $error("value_res: expected %h, got %h", e.value, rsp_value_res);
                  fail_count++;
               end
               if (rsp_error !== e.error) begin
                  $error("error: expected %0d, got %0d", e.error, rsp_error);
                  fail_count++;
               end
            end
         end
      end
      pending = solver_rsp_q.size();
   end

   final begin
   end

endmodule

[tb/tb_iterative_linear_solver_unit.sv]
// Top of the iterative_linear_solver_unit testbench: clock, reset, register
// writes, request and response traffic and the verdict. Uses ils_pkg and
// ils_result_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_iterative_linear_solver_unit;
   import ils_pkg::*;

   localparam logic [METHOD_W-1:0] METHOD_SPARE = 2'd3;
   localparam logic [DATA_W-1:0]   MAX_RELAX    = (64'd1 << RELAX_W) - 1;

   logic              clock;
   logic              reset;
   logic              req_valid, req_ready;
   logic [1:0]        req_type;
   logic [ROW_W-1:0]  req_row, req_col;
   logic [DATA_W-1:0] req_value;
   logic              rsp_valid, rsp_ready, rsp_kind, rsp_error;
   logic [ROW_W-1:0]  rsp_index;
   logic [DATA_W-1:0] rsp_value_res;
   logic              psel, penable, pwrite, pready;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;
   int                fail_count, pending;
   int                items_sent;
   int                req_burst, rsp_burst;
   bit                hold_rsp;

   iterative_linear_solver_unit dut (.*);

   ils_result_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int gap;
      rsp_ready <= 0;
      rsp_burst = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end else begin
            if (rsp_burst > 0) begin
               gap = 0;
               rsp_burst--;
            end else begin
               gap = $urandom_range(0, 6);
               if ($urandom_range(0, 19) == 0) rsp_burst = 15;
            end
            if (gap > 0) begin
               rsp_ready <= 0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send(logic [1:0] t, logic [ROW_W-1:0] r, logic [ROW_W-1:0] c,
                       logic [DATA_W-1:0] v);
      int gap;
      if (req_burst > 0) begin
         gap = 0;
         req_burst--;
      end else begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 19) == 0) req_burst = 15;
      end
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_type <= t;
      req_row <= r;
      req_col <= c;
      req_value <= v;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] v);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 3'b000};
      pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
   endtask

   task automatic configure(logic [METHOD_W-1:0] m, logic [SWEEP_W-1:0] sw,
                            logic [DATA_W-1:0] w, logic [SIZE_W-1:0] sz);
      drain();
      reg_write(REG_METHOD, m);
      reg_write(REG_SWEEPS, sw);
      reg_write(REG_RELAX, w);
      reg_write(REG_SIZE, sz);
   endtask

   function automatic logic [DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [DATA_W-1:0] small_fx(int span_bits);
      logic [DATA_W-1:0] v;
      v = rand64() >> (DATA_W - span_bits);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   // style 0 well-conditioned, 1 zero diagonal somewhere, 2 raw 64-bit values
   task automatic load_system(int n, int style);
      int zr;
      zr = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            if (style == 2) send(REQ_WR_MATRIX, i, j, rand64());
            else if (i != j) send(REQ_WR_MATRIX, i, j, small_fx(FRAC_BITS));
            else if (style == 1 && i == zr) send(REQ_WR_MATRIX, i, j, '0);
            else send(REQ_WR_MATRIX, i, j,
                      (DATA_W'($urandom_range(2, 9)) << FRAC_BITS) | small_fx(FRAC_BITS));
         end
         send(REQ_WR_RHS, i, 0, (style == 2) ? rand64() : small_fx(FRAC_BITS + 3));
      end
   endtask

   task automatic noise_item();
      case ($urandom_range(0, 2))
         0: send(REQ_WR_MATRIX, $urandom, $urandom, rand64());
         1: send(REQ_WR_RHS, $urandom, $urandom, rand64());
         default: send(REQ_READ, $urandom, $urandom, rand64());
      endcase
   endtask

   task automatic solve_round();
      int                n, style;
      logic [DATA_W-1:0] w;
      logic [SIZE_W-1:0] sz;
      n = $urandom_range(1, 5);
      sz = ($urandom_range(0, 9) == 0 && n == 1) ? '0 : SIZE_W'(n);
      case ($urandom_range(0, 4))
         0: w = '0;
         1: w = ONE_FX;
         2: w = MAX_RELAX;
         default: w = rand64() & (ONE_FX * 2 - 1);
      endcase
      configure($urandom_range(0, 3), $urandom_range(0, 4), w, sz);
      style = $urandom_range(0, 9);
      load_system(n, style < 7 ? 0 : style < 9 ? 1 : 2);
      send(REQ_START, $urandom, $urandom, rand64());
      repeat ($urandom_range(1, 4))
         send(REQ_READ, $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, n - 1),
              $urandom, rand64());
   endtask

   initial begin
      reset <= 1;
      req_valid <= 0;
      req_type <= REQ_READ;
      req_row <= 0;
      req_col <= 0;
      req_value <= 0;
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      paddr <= 0;
      pwdata <= 0;
      items_sent = 0;
      req_burst = 0;
      hold_rsp = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(REQ_READ, 0, 0, '0);
      send(REQ_READ, 127, 127, '1);
      configure(METHOD_JACOBI, 16'hFFFF, MAX_RELAX, 8'd2);
      configure(METHOD_JACOBI, 2, ONE_FX, 8'd2);
      send(REQ_WR_MATRIX, 127, 127, 64'h7FFF_FFFF_FFFF_FFFF);
      send(REQ_WR_RHS, 127, 0, 64'h8000_0000_0000_0000);
      send(REQ_WR_MATRIX, 0, 0, ONE_FX);
      send(REQ_WR_MATRIX, 0, 1, 64'h8000_0000_0000_0000);
      send(REQ_WR_MATRIX, 1, 0, 64'h7FFF_FFFF_FFFF_FFFF);
      send(REQ_WR_MATRIX, 1, 1, ONE_FX);
      send(REQ_WR_RHS, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
      send(REQ_WR_RHS, 1, 0, 64'h8000_0000_0000_0000);
      send(REQ_START, 0, 0, '0);
      send(REQ_READ, 0, 0, '0);
      send(REQ_READ, 1, 0, '0);
      send(REQ_READ, 127, 0, '0);
      configure(METHOD_GS, 0, '0, 8'd0);
      send(REQ_START, 0, 0, '0);
      send(REQ_READ, 0, 0, '0);
      configure(METHOD_SOR, 0, MAX_RELAX, 8'd255);
      send(REQ_START, 0, 0, '0);
      send(REQ_READ, 127, 0, '0);
      configure(METHOD_SPARE, 1, ONE_FX, 8'd1);
      send(REQ_WR_MATRIX, 0, 0, '0);
      send(REQ_WR_RHS, 0, 0, ONE_FX);
      send(REQ_START, 0, 0, '0);
      send(REQ_READ, 0, 0, '0);

      hold_rsp = 1;
      repeat (8) send(REQ_READ, $urandom, 0, '0);
      drain();

      while (items_sent < 450) begin
         if ($urandom_range(0, 9) < 7) solve_round();
         else repeat (5) noise_item();
      end
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

[files.f]
hw/rtl/ils_pkg.sv
hw/rtl/ils_arith.sv
hw/rtl/ils_core.sv
hw/rtl/iterative_linear_solver_unit.sv
tb/ils_result_checker.sv
tb/tb_iterative_linear_solver_unit.sv
